[rtl/triangle_cevian_lengths_macros.svh]
// Assertion macros for the triangle cevian lengths block.
// Used by modules that check their own control logic; no other dependencies.
`ifndef TRIANGLE_CEVIAN_LENGTHS_MACROS_SVH
`define TRIANGLE_CEVIAN_LENGTHS_MACROS_SVH
`ifndef SYNTHESIS
`define TCL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("property check failed");
`define TCL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
`define TCL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define TCL_ASSERT(lbl, clk, rst_n, prop)
`define TCL_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TCL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/tcl_pkg.sv]
// Shared types and constants for the triangle cevian lengths block.
// No dependencies.
`timescale 1ns / 1ps
package tcl_pkg;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  localparam int unsigned QUEUE_DEPTH = 2;

  // radicand slots carried from front to back
  localparam int unsigned N_LEN     = 7;
  localparam int unsigned MED_BASE  = 0;
  localparam int unsigned BIS_BASE  = 3;
  localparam int unsigned HERON_IDX = 6;

  // root coefficient slots
  localparam int unsigned N_COEF    = 6;
  localparam int unsigned KBIS_BASE = 0;
  localparam int unsigned KALT_BASE = 3;

  // median: (2q)^2 <= 2b^2 + 2c^2 - a^2
  localparam int unsigned MEDIAN_COEF = 4;

endpackage

[rtl/tcl_front.sv]
// Front end: accepts side words, checks the triangle inequality and forms
// every radicand and the bisector and altitude root coefficients. Depends on tcl_pkg.
`timescale 1ns / 1ps
module tcl_front #(
  parameter int unsigned SIDE_WIDTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        valid_i,
  output logic                                        stall_o,
  input  logic [SIDE_WIDTH-1:0]                       side_a_i,
  input  logic [SIDE_WIDTH-1:0]                       side_b_i,
  input  logic [SIDE_WIDTH-1:0]                       side_c_i,
  input  tcl_pkg::queue_status_t                      status_i,
  output logic                                        valid_o,
  output logic                                        tri_ok_o,
  output logic [tcl_pkg::N_LEN-1:0][4*SIDE_WIDTH+1:0]  len_o,
  output logic [tcl_pkg::N_COEF-1:0][2*SIDE_WIDTH+1:0] coef_o
);

  localparam int unsigned W  = SIDE_WIDTH;
  localparam int unsigned H  = W + 2;
  localparam int unsigned DW = 4 * W + 2;
  localparam int unsigned KW = 2 * W + 2;
  localparam int unsigned MW = 2 * W + 3;

  logic en;

  // stage 1
  logic [W:0]   sa, sb, sc, ea, eb, ec;
  logic [W+1:0] per;
  logic         ok;
  logic         v1_q, ok1_q;
  logic [W-1:0] a1_q, b1_q, c1_q;
  logic [W:0]   sa1_q, sb1_q, sc1_q, ea1_q, eb1_q, ec1_q;
  logic [W+1:0] per1_q;

  // stage 2
  logic          v2_q, ok2_q;
  logic [2*W-1:0] sqa2_q, sqb2_q, sqc2_q, pbc2_q, pac2_q, pab2_q;
  logic [MW-1:0] ma2_q, mb2_q, mc2_q;
  logic [KW-1:0] ka2_q, kb2_q, kc2_q, h2_q;

  // stage 3
  logic                      v3_q, ok3_q;
  logic [3:0][2*H-1:0]       opx, opy;
  logic [3:0][3:0][2*H-1:0]  pp_q;
  logic [2:0][DW-1:0]        med3_q;
  logic [tcl_pkg::N_COEF-1:0][KW-1:0] coef3_q;

  // stage 4
  logic [3:0][DW-1:0] prod;
  logic               v4_q, ok4_q;
  logic [tcl_pkg::N_LEN-1:0][DW-1:0]  len4_q;
  logic [tcl_pkg::N_COEF-1:0][KW-1:0] coef4_q;

  assign en      = !(v4_q && status_i.full);
  assign stall_o = !en;

  always_comb begin
    sa  = {1'b0, side_b_i} + {1'b0, side_c_i};
    sb  = {1'b0, side_a_i} + {1'b0, side_c_i};
    sc  = {1'b0, side_a_i} + {1'b0, side_b_i};
    per = {2'b00, side_a_i} + {2'b00, side_b_i} + {2'b00, side_c_i};
    ok  = (sa > {1'b0, side_a_i}) && (sb > {1'b0, side_b_i}) && (sc > {1'b0, side_c_i});
    ea  = sa - {1'b0, side_a_i};
    eb  = sb - {1'b0, side_b_i};
    ec  = sc - {1'b0, side_c_i};
  end

  // wide products split into four half-width partials
  always_comb begin
    opx[0] = (2*H)'(ma2_q);  opy[0] = (2*H)'(h2_q);
    opx[1] = (2*H)'(pbc2_q); opy[1] = (2*H)'(ma2_q);
    opx[2] = (2*H)'(pac2_q); opy[2] = (2*H)'(mb2_q);
    opx[3] = (2*H)'(pab2_q); opy[3] = (2*H)'(mc2_q);
  end

  always_comb begin
    for (int p = 0; p < 4; p++) begin
      prod[p] = (DW'(pp_q[p][3]) << (2 * H))
              + ((DW'(pp_q[p][2]) + DW'(pp_q[p][1])) << H)
              + DW'(pp_q[p][0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ok1_q  <= ok;
      a1_q   <= side_a_i;
      b1_q   <= side_b_i;
      c1_q   <= side_c_i;
      sa1_q  <= sa;
      sb1_q  <= sb;
      sc1_q  <= sc;
      ea1_q  <= ea;
      eb1_q  <= eb;
      ec1_q  <= ec;
      per1_q <= per;

      ok2_q  <= ok1_q;
      sqa2_q <= (2*W)'(a1_q) * (2*W)'(a1_q);
      sqb2_q <= (2*W)'(b1_q) * (2*W)'(b1_q);
      sqc2_q <= (2*W)'(c1_q) * (2*W)'(c1_q);
      pbc2_q <= (2*W)'(b1_q) * (2*W)'(c1_q);
      pac2_q <= (2*W)'(a1_q) * (2*W)'(c1_q);
      pab2_q <= (2*W)'(a1_q) * (2*W)'(b1_q);
      ma2_q  <= MW'(ea1_q) * MW'(per1_q);
      mb2_q  <= MW'(eb1_q) * MW'(per1_q);
      mc2_q  <= MW'(ec1_q) * MW'(per1_q);
      ka2_q  <= KW'(sa1_q) * KW'(sa1_q);
      kb2_q  <= KW'(sb1_q) * KW'(sb1_q);
      kc2_q  <= KW'(sc1_q) * KW'(sc1_q);
      h2_q   <= KW'(eb1_q) * KW'(ec1_q);

      ok3_q <= ok2_q;
      for (int p = 0; p < 4; p++) begin
        pp_q[p][0] <= (2*H)'(opx[p][H-1:0])   * (2*H)'(opy[p][H-1:0]);
        pp_q[p][1] <= (2*H)'(opx[p][H-1:0])   * (2*H)'(opy[p][2*H-1:H]);
        pp_q[p][2] <= (2*H)'(opx[p][2*H-1:H]) * (2*H)'(opy[p][H-1:0]);
        pp_q[p][3] <= (2*H)'(opx[p][2*H-1:H]) * (2*H)'(opy[p][2*H-1:H]);
      end
      med3_q[0] <= ((DW'(sqb2_q) + DW'(sqc2_q)) << 1) - DW'(sqa2_q);
      med3_q[1] <= ((DW'(sqa2_q) + DW'(sqc2_q)) << 1) - DW'(sqb2_q);
      med3_q[2] <= ((DW'(sqa2_q) + DW'(sqb2_q)) << 1) - DW'(sqc2_q);
      coef3_q[tcl_pkg::KBIS_BASE]     <= ka2_q;
      coef3_q[tcl_pkg::KBIS_BASE + 1] <= kb2_q;
      coef3_q[tcl_pkg::KBIS_BASE + 2] <= kc2_q;
      coef3_q[tcl_pkg::KALT_BASE]     <= {sqa2_q, 2'b00};
      coef3_q[tcl_pkg::KALT_BASE + 1] <= {sqb2_q, 2'b00};
      coef3_q[tcl_pkg::KALT_BASE + 2] <= {sqc2_q, 2'b00};

      ok4_q <= ok3_q;
      for (int s = 0; s < 3; s++) begin
        len4_q[tcl_pkg::MED_BASE + s] <= med3_q[s];
        len4_q[tcl_pkg::BIS_BASE + s] <= prod[s + 1];
      end
      len4_q[tcl_pkg::HERON_IDX] <= prod[0];
      coef4_q <= coef3_q;
    end
  end

  assign valid_o  = v4_q;
  assign tri_ok_o = ok4_q;
  assign len_o    = len4_q;
  assign coef_o   = coef4_q;

endmodule

[rtl/tcl_queue.sv]
// Short word queue between front end and root back end.
// Depends on tcl_pkg and triangle_cevian_lengths_macros.svh.
`timescale 1ns / 1ps
`include "triangle_cevian_lengths_macros.svh"
module tcl_queue #(
  parameter int unsigned DEPTH  = 2,
  parameter int unsigned DATA_W = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic [DATA_W-1:0]      data_i,
  input  logic                   pop_i,
  output logic [DATA_W-1:0]      data_o,
  output tcl_pkg::queue_status_t status_o
);

  localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CNTW-1:0]   count_q, count_d;

  always_comb begin
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + CNTW'(1);
      2'b01:   count_d = count_q - CNTW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o          = mem_q[rd_ptr_q];
  assign status_o.full   = (count_q == CNTW'(DEPTH));
  assign status_o.empty  = (count_q == '0);

  `TCL_ASSERT_IMP(a_no_overflow, clk_i, rst_ni, push_i, !status_o.full)
  `TCL_ASSERT_IMP(a_no_underflow, clk_i, rst_ni, pop_i, !status_o.empty)
  `TCL_ASSERT_NEXT(a_count_up, clk_i, rst_ni, push_i && !pop_i, count_q == $past(count_q) + CNTW'(1))
  `TCL_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CNTW'(DEPTH))

endmodule

[rtl/tcl_root.sv]
// Pipelined root-quotient unit: largest q with coef * q^2 <= radicand,
// one result bit per stage. Standalone; no package use.
`timescale 1ns / 1ps
module tcl_root #(
  parameter int unsigned SIDE_WIDTH = 16,
  parameter int unsigned REM_W      = 66,
  parameter int unsigned COEF_W     = 34
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [REM_W-1:0]      rem_i,
  input  logic [COEF_W-1:0]     coef_i,
  output logic [SIDE_WIDTH-1:0] root_o
);

  localparam int unsigned W  = SIDE_WIDTH;
  localparam int unsigned MW = COEF_W + W;
  localparam int unsigned TW = COEF_W + 2 * W + 1;
  localparam int unsigned CW = (TW > REM_W) ? TW : REM_W;

  // rem = radicand - coef*q^2, m = coef*q
  logic [REM_W-1:0]  rem_q  [W];
  logic [MW-1:0]     m_q    [W];
  logic [COEF_W-1:0] k_q    [W];
  logic [W-1:0]      q_q    [W];

  for (genvar i = 0; i < W; i++) begin : g_stage
    localparam int unsigned B = W - 1 - i;
    logic [REM_W-1:0]  rem_in;
    logic [MW-1:0]     m_in;
    logic [COEF_W-1:0] k_in;
    logic [W-1:0]      q_in;
    logic [CW-1:0]     trial;
    logic              fit;

    if (i == 0) begin : g_first
      assign rem_in = rem_i;
      assign m_in   = '0;
      assign k_in   = coef_i;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign m_in   = m_q[i-1];
      assign k_in   = k_q[i-1];
      assign q_in   = q_q[i-1];
    end

    assign trial = (CW'(m_in) << (B + 1)) + (CW'(k_in) << (2 * B));
    assign fit   = (trial <= CW'(rem_in));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= fit ? REM_W'(CW'(rem_in) - trial) : rem_in;
        m_q[i]   <= fit ? (m_in + (MW'(k_in) << B)) : m_in;
        k_q[i]   <= k_in;
        q_q[i]   <= fit ? (q_in | (W'(1) << B)) : q_in;
      end
    end
  end

  assign root_o = q_q[W-1];

endmodule

[rtl/triangle_cevian_lengths.sv]
// Throughput: one word per cycle, held while stall_i back-pressure fills the queue;
// each of the nine root units resolves one result bit per pipeline stage, and the
// front end forms radicands in four stages.
// Reset clears all valid flags and empties the queue; data registers are not reset.
// Depends on tcl_pkg, tcl_front, tcl_queue, tcl_root.
`timescale 1ns / 1ps
module triangle_cevian_lengths #(
  parameter int unsigned SIDE_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  stall_o,
  input  logic [SIDE_WIDTH-1:0] side_a_i,
  input  logic [SIDE_WIDTH-1:0] side_b_i,
  input  logic [SIDE_WIDTH-1:0] side_c_i,
  output logic                  valid_o,
  input  logic                  stall_i,
  output logic                  valid_res_o,
  output logic [SIDE_WIDTH-1:0] median_a_o,
  output logic [SIDE_WIDTH-1:0] median_b_o,
  output logic [SIDE_WIDTH-1:0] median_c_o,
  output logic [SIDE_WIDTH-1:0] bisector_a_o,
  output logic [SIDE_WIDTH-1:0] bisector_b_o,
  output logic [SIDE_WIDTH-1:0] bisector_c_o,
  output logic [SIDE_WIDTH-1:0] altitude_a_o,
  output logic [SIDE_WIDTH-1:0] altitude_b_o,
  output logic [SIDE_WIDTH-1:0] altitude_c_o
);

  localparam int unsigned W  = SIDE_WIDTH;
  localparam int unsigned DW = 4 * W + 2;
  localparam int unsigned KW = 2 * W + 2;
  localparam int unsigned QW = 1 + tcl_pkg::N_LEN * DW + tcl_pkg::N_COEF * KW;

  logic                               f_valid, f_ok;
  logic [tcl_pkg::N_LEN-1:0][DW-1:0]  f_len, h_len;
  logic [tcl_pkg::N_COEF-1:0][KW-1:0] f_coef, h_coef;
  logic                               h_ok;
  tcl_pkg::queue_status_t             q_status;
  logic                               push, pop, b_en;
  logic [QW-1:0]                      q_dout;
  logic [W-1:0]                       vpipe_q, okpipe_q;
  logic [2:0][W-1:0]                  med_r, bis_r, alt_r;

  tcl_front #(
    .SIDE_WIDTH(SIDE_WIDTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (valid_i),
    .stall_o  (stall_o),
    .side_a_i (side_a_i),
    .side_b_i (side_b_i),
    .side_c_i (side_c_i),
    .status_i (q_status),
    .valid_o  (f_valid),
    .tri_ok_o (f_ok),
    .len_o    (f_len),
    .coef_o   (f_coef)
  );

  assign push = f_valid && !q_status.full;
  assign b_en = !(vpipe_q[W-1] && stall_i);
  assign pop  = b_en && !q_status.empty;

  tcl_queue #(
    .DEPTH  (tcl_pkg::QUEUE_DEPTH),
    .DATA_W (QW)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   ({f_ok, f_len, f_coef}),
    .pop_i    (pop),
    .data_o   (q_dout),
    .status_o (q_status)
  );

  assign {h_ok, h_len, h_coef} = q_dout;

  for (genvar s = 0; s < 3; s++) begin : g_side
    tcl_root #(
      .SIDE_WIDTH (SIDE_WIDTH),
      .REM_W      (DW),
      .COEF_W     (KW)
    ) u_med (
      .clk_i  (clk_i),
      .en_i   (b_en),
      .rem_i  (h_len[tcl_pkg::MED_BASE + s]),
      .coef_i (KW'(tcl_pkg::MEDIAN_COEF)),
      .root_o (med_r[s])
    );

    tcl_root #(
      .SIDE_WIDTH (SIDE_WIDTH),
      .REM_W      (DW),
      .COEF_W     (KW)
    ) u_bis (
      .clk_i  (clk_i),
      .en_i   (b_en),
      .rem_i  (h_len[tcl_pkg::BIS_BASE + s]),
      .coef_i (h_coef[tcl_pkg::KBIS_BASE + s]),
      .root_o (bis_r[s])
    );

    tcl_root #(
      .SIDE_WIDTH (SIDE_WIDTH),
      .REM_W      (DW),
      .COEF_W     (KW)
    ) u_alt (
      .clk_i  (clk_i),
      .en_i   (b_en),
      .rem_i  (h_len[tcl_pkg::HERON_IDX]),
      .coef_i (h_coef[tcl_pkg::KALT_BASE + s]),
      .root_o (alt_r[s])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vpipe_q <= '0;
    end else if (b_en) begin
      vpipe_q <= {vpipe_q[W-2:0], !q_status.empty};
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_en) begin
      okpipe_q <= {okpipe_q[W-2:0], h_ok};
    end
  end

  assign valid_o      = vpipe_q[W-1];
  assign valid_res_o  = okpipe_q[W-1];
  assign median_a_o   = okpipe_q[W-1] ? med_r[0] : '0;
  assign median_b_o   = okpipe_q[W-1] ? med_r[1] : '0;
  assign median_c_o   = okpipe_q[W-1] ? med_r[2] : '0;
  assign bisector_a_o = okpipe_q[W-1] ? bis_r[0] : '0;
  assign bisector_b_o = okpipe_q[W-1] ? bis_r[1] : '0;
  assign bisector_c_o = okpipe_q[W-1] ? bis_r[2] : '0;
  assign altitude_a_o = okpipe_q[W-1] ? alt_r[0] : '0;
  assign altitude_b_o = okpipe_q[W-1] ? alt_r[1] : '0;
  assign altitude_c_o = okpipe_q[W-1] ? alt_r[2] : '0;

endmodule

[test/tb_top.sv]
// Self-checking testbench for triangle_cevian_lengths: random and directed side words,
// with an exact integer predictor for the medians, bisectors and altitudes.
// Depends on the RTL top level only.
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned SW = 16;
  localparam int unsigned N_OUT = 9;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef logic [127:0] wide_t;

  typedef struct {
    logic          ok;
    logic [SW-1:0] len [N_OUT];
  } cevians_t;

  logic          clk_i;
  logic          rst_ni;
  logic          valid_i;
  logic          stall_o;
  logic [SW-1:0] side_a_i, side_b_i, side_c_i;
  logic          valid_o;
  logic          stall_i;
  logic          valid_res_o;
  logic [SW-1:0] median_a_o, median_b_o, median_c_o;
  logic [SW-1:0] bisector_a_o, bisector_b_o, bisector_c_o;
  logic [SW-1:0] altitude_a_o, altitude_b_o, altitude_c_o;

  cevians_t    pending_cevians[$];
  int unsigned mismatches;
  int unsigned words_sent;
  int unsigned words_checked;
  int unsigned valid_triangles;
  int unsigned cycles;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  triangle_cevian_lengths #(.SIDE_WIDTH(SW)) dut (
    .clk_i, .rst_ni, .valid_i, .stall_o, .side_a_i, .side_b_i, .side_c_i,
    .valid_o, .stall_i, .valid_res_o,
    .median_a_o, .median_b_o, .median_c_o,
    .bisector_a_o, .bisector_b_o, .bisector_c_o,
    .altitude_a_o, .altitude_b_o, .altitude_c_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // largest q below 2^SW with (q*d)^2 + extra <= y
  function automatic logic [SW-1:0] root_quotient(wide_t y, wide_t extra, wide_t d);
    logic [SW-1:0] q;
    logic [SW-1:0] t;
    wide_t p;
    q = '0;
    for (int bit_i = SW - 1; bit_i >= 0; bit_i--) begin
      t = q | (SW'(1) << bit_i);
      p = wide_t'(t) * d;
      if (p * p + extra <= y) q = t;
    end
    return q;
  endfunction

  function automatic cevians_t predict_cevians(logic [SW-1:0] a, logic [SW-1:0] b,
                                               logic [SW-1:0] c);
    cevians_t r;
    wide_t x[3];
    wide_t heron;
    wide_t u, v, s;
    r.ok = 1'b0;
    for (int i = 0; i < N_OUT; i++) r.len[i] = '0;
    x[0] = wide_t'(a);
    x[1] = wide_t'(b);
    x[2] = wide_t'(c);
    if (!(x[0] + x[1] > x[2] && x[0] + x[2] > x[1] && x[1] + x[2] > x[0])) return r;
    r.ok = 1'b1;
    heron = (x[0] + x[1] + x[2]) * (x[1] + x[2] - x[0]) * (x[0] + x[2] - x[1])
          * (x[0] + x[1] - x[2]);
    for (int i = 0; i < 3; i++) begin
      u = x[(i + 1) % 3];
      v = x[(i + 2) % 3];
      s = u + v;
      r.len[i]     = root_quotient(2 * u * u + 2 * v * v, x[i] * x[i], 2);
      r.len[3 + i] = root_quotient(u * v * (s - x[i]) * (s + x[i]), '0, s);
      r.len[6 + i] = root_quotient(heron, '0, 2 * x[i]);
    end
    return r;
  endfunction

  task automatic send_sides(logic [SW-1:0] a, logic [SW-1:0] b, logic [SW-1:0] c);
    cevians_t e;
    @(negedge clk_i);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(negedge clk_i);
    end
    valid_i  <= 1'b1;
    side_a_i <= a;
    side_b_i <= b;
    side_c_i <= c;
    do @(posedge clk_i); while (stall_o);
    e = predict_cevians(a, b, c);
    if (e.ok) valid_triangles++;
    pending_cevians.push_back(e);
    words_sent++;
  endtask

  // receiver stall
  always @(negedge clk_i) begin
    if (rst_ni) stall_i <= ($urandom_range(99, 0) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cevians_t e;
    logic [SW-1:0] got [N_OUT];
    logic bad;
    if (rst_ni && valid_o && !stall_i) begin
      got = '{median_a_o, median_b_o, median_c_o, bisector_a_o, bisector_b_o,
              bisector_c_o, altitude_a_o, altitude_b_o, altitude_c_o};
      if (pending_cevians.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word at cycle %0d", cycles);
      end else begin
        e = pending_cevians.pop_front();
        bad = (valid_res_o !== e.ok);
        for (int i = 0; i < N_OUT; i++) if (got[i] !== e.len[i]) bad = 1'b1;
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch word %0d: valid exp %0b got %0b", words_checked, e.ok,
                     valid_res_o);
            for (int i = 0; i < N_OUT; i++)
              $display("  length %0d exp %h got %h", i, e.len[i], got[i]);
          end
        end
        words_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  task automatic test_directed();
    send_sides(16'h0000, 16'h0000, 16'h0000);
    send_sides(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_sides(16'h0001, 16'h0001, 16'h0001);
    send_sides(16'h0001, 16'h0001, 16'h0002);
    send_sides(16'h0002, 16'h0001, 16'h0001);
    send_sides(16'h0001, 16'h0002, 16'h0001);
    send_sides(16'h0000, 16'h0500, 16'h0500);
    send_sides(16'h0500, 16'h0000, 16'h0500);
    send_sides(16'h0500, 16'h0500, 16'h0000);
    send_sides(16'h0300, 16'h0400, 16'h0500);
    send_sides(16'hFFFF, 16'hFFFF, 16'h0001);
    send_sides(16'h0001, 16'hFFFF, 16'hFFFF);
    send_sides(16'hFFFF, 16'h0001, 16'hFFFF);
    send_sides(16'hFFFF, 16'h7FFF, 16'h8000);
    send_sides(16'hFFFF, 16'h7FFF, 16'h7FFF);
    send_sides(16'hAAAA, 16'h5555, 16'hAAAA);
    send_sides(16'h5555, 16'hAAAA, 16'h5555);
    send_sides(16'hFFFF, 16'h0000, 16'h0000);
    send_sides(16'h0100, 16'h0100, 16'h0100);
    send_sides(16'h0800, 16'h0100, 16'h0100);
  endtask

  task automatic test_random(int unsigned n_words);
    logic [SW-1:0] s[3];
    int unsigned lo, hi, top, rot;
    for (int unsigned k = 0; k < n_words; k++) begin
      top = ($urandom_range(9, 0) < 7) ? 65535 : 255;
      s[0] = SW'($urandom_range(top, 1));
      s[1] = SW'($urandom_range(top, 1));
      if ($urandom_range(9, 0) < 8) begin
        lo = ((s[0] > s[1]) ? s[0] - s[1] : s[1] - s[0]) + 1;
        hi = s[0] + s[1] - 1;
        if (hi > 65535) hi = 65535;
        s[2] = SW'($urandom_range(hi, lo));
      end else begin
        s[0] = SW'($urandom);
        s[1] = SW'($urandom);
        s[2] = SW'($urandom);
      end
      rot = $urandom_range(2, 0);
      send_sides(s[rot], s[(rot + 1) % 3], s[(rot + 2) % 3]);
    end
  endtask

  initial begin
    rst_ni   = 1'b0;
    valid_i  = 1'b0;
    stall_i  = 1'b0;
    side_a_i = '0;
    side_b_i = '0;
    side_c_i = '0;
    mismatches = 0;
    words_sent = 0;
    words_checked = 0;
    valid_triangles = 0;
    cycles = 0;
    send_idle_pct = 7;
    recv_idle_pct = 53;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random(480);
    send_idle_pct = 53;
    recv_idle_pct = 7;
    test_random(500);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(500);
    @(negedge clk_i);
    valid_i <= 1'b0;
    while (pending_cevians.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("sent %0d side words (%0d valid triangles), checked %0d result words",
             words_sent, valid_triangles, words_checked);
    $display("three idle profiles, %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/tcl_pkg.sv
rtl/tcl_front.sv
rtl/tcl_queue.sv
rtl/tcl_root.sv
rtl/triangle_cevian_lengths.sv
test/tb_top.sv
